FILE: rtl/core/tofd_pkg.sv
`default_nettype none

package tofd_pkg;

	// fixed field widths
	localparam int SAMPLE_W   = 16;
	localparam int DIFF_W     = 17;
	localparam int ANGLE_W    = 20;  // signed Q.16 radians
	localparam int DEPTH_W    = 18;
	localparam int CONF_W     = 17;
	localparam int OFFSET_W   = 16;
	localparam int SCALE_W    = 18;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_OFFSET  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MM_PER_RADIAN = 2'd1;

	localparam logic [OFFSET_W-1:0] DEPTH_OFFSET_RST  = OFFSET_W'(24000);
	localparam logic [SCALE_W-1:0]  MM_PER_RADIAN_RST = SCALE_W'(81487);

	// CORDIC
	localparam int CORDIC_STEPS  = 16;
	localparam int CORDIC_STAGES = 8;
	localparam int ATAN_IDX_W    = 4;

	localparam logic signed [ANGLE_W-1:0] HALF_PI_Q16    = ANGLE_W'(102944);
	localparam logic signed [ANGLE_W-1:0] TWO_PI_Q16     = ANGLE_W'(411775);
	localparam logic signed [ANGLE_W-1:0] WRAP_LIMIT_Q16 = -ANGLE_W'(65536);

	// round(atan(2^-i) * 2^16)
	localparam logic [15:0] ATAN_Q16 [CORDIC_STEPS] = '{
		16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
		16'd256,   16'd128,   16'd64,    16'd32,   16'd16,   16'd8,    16'd4,    16'd2
	};

	typedef struct packed {
		logic                      valid;
		logic                      zero;   // both differences zero
		logic signed [ANGLE_W-1:0] angle;
	} phase_t;

	typedef struct packed {
		logic                      valid;
		logic                      sat;
		logic signed [DEPTH_W-1:0] depth;
	} depth_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/tofd_cordic.sv
`default_nettype none

module tofd_cordic (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	input  wire logic signed [tofd_pkg::DIFF_W-1:0]  d0,
	input  wire logic signed [tofd_pkg::DIFF_W-1:0]  d1,
	output tofd_pkg::phase_t                         phase
);

	localparam int XY_W      = 35;
	localparam int PRE_SHIFT = 14;
	localparam int STAGES    = tofd_pkg::CORDIC_STAGES;
	localparam int STEPS_PER = tofd_pkg::CORDIC_STEPS / tofd_pkg::CORDIC_STAGES;

	typedef struct packed {
		logic signed [XY_W-1:0]              x;
		logic signed [XY_W-1:0]              y;
		logic signed [tofd_pkg::ANGLE_W-1:0] z;
	} rot_t;

	function automatic rot_t rot_step(input rot_t a, input int i);
		rot_t                                b;
		logic signed [XY_W-1:0]              xs;
		logic signed [XY_W-1:0]              ys;
		logic signed [tofd_pkg::ANGLE_W-1:0] da;
		xs = a.x >>> i;
		ys = a.y >>> i;
		da = tofd_pkg::ANGLE_W'(tofd_pkg::ATAN_Q16[tofd_pkg::ATAN_IDX_W'(i)]);
		if (!a.y[XY_W-1]) begin
			b.x = a.x + ys;
			b.y = a.y - xs;
			b.z = a.z + da;
		end else begin
			b.x = a.x - ys;
			b.y = a.y + xs;
			b.z = a.z - da;
		end
		return b;
	endfunction

	logic valid_s [0:STAGES];
	logic zero_s  [0:STAGES];
	rot_t rot_s   [0:STAGES];

	rot_t                   pre_c;
	rot_t                   nxt_c [1:STAGES];
	logic signed [XY_W-1:0] x0_c;
	logic signed [XY_W-1:0] y0_c;

	// quarter turn into the right half plane
	always_comb begin
		x0_c = {{(XY_W-tofd_pkg::DIFF_W-PRE_SHIFT){d0[tofd_pkg::DIFF_W-1]}}, d0,
			{PRE_SHIFT{1'b0}}};
		y0_c = {{(XY_W-tofd_pkg::DIFF_W-PRE_SHIFT){d1[tofd_pkg::DIFF_W-1]}}, d1,
			{PRE_SHIFT{1'b0}}};
		pre_c.x = x0_c;
		pre_c.y = y0_c;
		pre_c.z = '0;
		if (d0[tofd_pkg::DIFF_W-1]) begin
			if (!d1[tofd_pkg::DIFF_W-1]) begin
				pre_c.x = y0_c;
				pre_c.y = -x0_c;
				pre_c.z = tofd_pkg::HALF_PI_Q16;
			end else begin
				pre_c.x = -y0_c;
				pre_c.y = x0_c;
				pre_c.z = -tofd_pkg::HALF_PI_Q16;
			end
		end
	end

	always_comb begin
		rot_t tmp;
		for (int k = 1; k <= STAGES; k++) begin
			tmp = rot_s[k-1];
			for (int j = 0; j < STEPS_PER; j++) begin
				tmp = rot_step(tmp, (k - 1) * STEPS_PER + j);
			end
			nxt_c[k] = tmp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STAGES; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else begin
			valid_s[0] <= in_valid;
			for (int k = 1; k <= STAGES; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		rot_s[0]  <= pre_c;
		zero_s[0] <= (d0 == '0) && (d1 == '0);
		for (int k = 1; k <= STAGES; k++) begin
			rot_s[k]  <= nxt_c[k];
			zero_s[k] <= zero_s[k-1];
		end
	end

	always_comb begin
		phase.valid = valid_s[STAGES];
		phase.zero  = zero_s[STAGES];
		phase.angle = rot_s[STAGES].z;
	end

endmodule

`default_nettype wire

FILE: rtl/core/tofd_sqrt.sv
`default_nettype none

module tofd_sqrt (
	input  wire logic                                clk,
	input  wire logic signed [tofd_pkg::DIFF_W-1:0]  d0,
	input  wire logic signed [tofd_pkg::DIFF_W-1:0]  d1,
	output logic             [tofd_pkg::CONF_W-1:0]  conf
);

	localparam int SQ_W     = 2 * tofd_pkg::DIFF_W;
	localparam int N_W      = 34;
	localparam int ROOT_W   = 18;
	localparam int T_W      = 36;
	localparam int BITS_PER = 2;
	localparam int STAGES   = ROOT_W / BITS_PER;

	typedef struct packed {
		logic [N_W-1:0]    rem;   // n - root^2
		logic [ROOT_W-1:0] root;
	} acc_t;

	// one restoring digit: try setting bit k of the root
	function automatic acc_t root_step(input acc_t a, input int k);
		acc_t           b;
		logic [T_W-1:0] t;
		t = (T_W'(a.root) << (k + 1)) | (T_W'(1) << (2 * k));
		b = a;
		if (T_W'(a.rem) >= t) begin
			b.rem  = a.rem - N_W'(t);
			b.root = a.root | (ROOT_W'(1) << k);
		end
		return b;
	endfunction

	logic signed [SQ_W-1:0] sq0_s1;
	logic signed [SQ_W-1:0] sq1_s1;
	acc_t                   acc_s [0:STAGES];
	acc_t                   nxt_c [1:STAGES];
	logic [ROOT_W-1:0]      conf_c;

	always_comb begin
		acc_t tmp;
		for (int m = 1; m <= STAGES; m++) begin
			tmp = acc_s[m-1];
			for (int j = 0; j < BITS_PER; j++) begin
				tmp = root_step(tmp, ROOT_W - 1 - ((m - 1) * BITS_PER + j));
			end
			nxt_c[m] = tmp;
		end
	end

	// round to nearest: bump when rem > root
	assign conf_c = acc_s[STAGES].root
		+ ROOT_W'(acc_s[STAGES].rem > N_W'(acc_s[STAGES].root));

	always_ff @(posedge clk) begin
		sq0_s1        <= d0 * d0;
		sq1_s1        <= d1 * d1;
		acc_s[0].rem  <= N_W'(sq0_s1[SQ_W-2:0]) + N_W'(sq1_s1[SQ_W-2:0]);
		acc_s[0].root <= '0;
		for (int m = 1; m <= STAGES; m++) begin
			acc_s[m] <= nxt_c[m];
		end
		conf <= conf_c[tofd_pkg::CONF_W-1:0];
	end

endmodule

`default_nettype wire

FILE: rtl/core/tofd_depth.sv
`default_nettype none

module tofd_depth (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire tofd_pkg::phase_t                      phase,
	input  wire logic [tofd_pkg::OFFSET_W-1:0]         offset,
	input  wire logic [tofd_pkg::SCALE_W-1:0]          scale,
	output tofd_pkg::depth_res_t                       res
);

	localparam int PROD_W  = tofd_pkg::SCALE_W + 1 + tofd_pkg::ANGLE_W;
	localparam int Q_SHIFT = 20;
	localparam int Q_W     = PROD_W + 1 - Q_SHIFT;
	localparam int DW      = 22;

	localparam logic signed [PROD_W:0] ROUND_BIAS = (PROD_W + 1)'(2 ** (Q_SHIFT - 1));
	localparam logic signed [DW-1:0]   D_MAX      = DW'((2 ** (tofd_pkg::DEPTH_W - 1)) - 1);
	localparam logic signed [DW-1:0]   D_MIN      = -D_MAX - DW'(1);

	logic                                valid_s1;
	logic signed [tofd_pkg::ANGLE_W-1:0] ang_s1;
	logic                                valid_s2;
	logic signed [PROD_W-1:0]            prod_s2;
	logic                                valid_s3;
	logic                                sat_s3;
	logic signed [tofd_pkg::DEPTH_W-1:0] depth_s3;

	logic signed [tofd_pkg::ANGLE_W-1:0] ang_c;
	logic signed [PROD_W-1:0]            prod_c;
	logic signed [PROD_W:0]              biased_c;
	logic signed [Q_W-1:0]               q_c;
	logic signed [DW-1:0]                raw_c;
	logic signed [DW-1:0]                clip_c;
	logic                                sat_c;

	always_comb begin
		if (phase.zero) begin
			ang_c = '0;
		end else if (phase.angle < tofd_pkg::WRAP_LIMIT_Q16) begin
			ang_c = phase.angle + tofd_pkg::TWO_PI_Q16;
		end else begin
			ang_c = phase.angle;
		end
	end

	assign prod_c = $signed({1'b0, scale}) * ang_s1;

	always_comb begin
		biased_c = {prod_s2[PROD_W-1], prod_s2} + ROUND_BIAS;
		q_c      = biased_c[PROD_W:Q_SHIFT];
		raw_c    = $signed({{(DW - tofd_pkg::OFFSET_W){1'b0}}, offset}) - DW'(q_c);
		sat_c    = 1'b1;
		if (raw_c > D_MAX) begin
			clip_c = D_MAX;
		end else if (raw_c < D_MIN) begin
			clip_c = D_MIN;
		end else begin
			clip_c = raw_c;
			sat_c  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= phase.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		ang_s1   <= ang_c;
		prod_s2  <= prod_c;
		depth_s3 <= clip_c[tofd_pkg::DEPTH_W-1:0];
		sat_s3   <= sat_c;
	end

	always_comb begin
		res.valid = valid_s3;
		res.sat   = sat_s3;
		res.depth = depth_s3;
	end

endmodule

`default_nettype wire

FILE: rtl/core/tof_four_phase_depth.sv
// Four-phase time-of-flight depth demodulation, fully pipelined.
// Throughput: one pixel per clock; busy is always low since the result side cannot stall.
// The pace is set by the 8-stage CORDIC (two iterations per stage) run in parallel with
// a 9-stage digit-by-digit square root (two root bits per stage).
// Reset (arst_n low, asynchronous): all valid bits clear, registers take their defaults.
`default_nettype none

module tof_four_phase_depth (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,

	// pixel in
	input  wire logic                                    start,
	output logic                                         busy,
	input  wire logic signed [tofd_pkg::SAMPLE_W-1:0]    phase_sample_0,
	input  wire logic signed [tofd_pkg::SAMPLE_W-1:0]    phase_sample_1,
	input  wire logic signed [tofd_pkg::SAMPLE_W-1:0]    phase_sample_2,
	input  wire logic signed [tofd_pkg::SAMPLE_W-1:0]    phase_sample_3,

	// register write
	input  wire logic                                    cfg_valid,
	output logic                                         cfg_ready,
	input  wire logic [tofd_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [tofd_pkg::CFG_DATA_W-1:0]         cfg_data,

	// result out, each done is a transfer
	output logic                                         done,
	output logic signed [tofd_pkg::DEPTH_W-1:0]          depth_q4,
	output logic        [tofd_pkg::CONF_W-1:0]           confidence,
	output logic                                         depth_saturated
);

	logic [tofd_pkg::OFFSET_W-1:0] depth_offset_q;
	logic [tofd_pkg::SCALE_W-1:0]  mm_per_radian_q;

	logic                                valid_s1;
	logic signed [tofd_pkg::DIFF_W-1:0]  d0_s1;
	logic signed [tofd_pkg::DIFF_W-1:0]  d1_s1;

	tofd_pkg::phase_t     phase;
	tofd_pkg::depth_res_t res;

	// Every stage advances each cycle and nothing downstream can push back,
	// so a new pixel is taken on any cycle.
	assign busy      = 1'b0;
	// Writes must land only while the pipe is drained; not enforced here, all are taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_offset_q  <= tofd_pkg::DEPTH_OFFSET_RST;
			mm_per_radian_q <= tofd_pkg::MM_PER_RADIAN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tofd_pkg::REG_DEPTH_OFFSET: begin
					depth_offset_q <= cfg_data[tofd_pkg::OFFSET_W-1:0];
				end
				tofd_pkg::REG_MM_PER_RADIAN: begin
					mm_per_radian_q <= cfg_data[tofd_pkg::SCALE_W-1:0];
				end
				default: begin
					// unmapped index: dropped
				end
			endcase
		end
	end

	// Stage 1: difference vector. 17 bits holds both differences exactly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		d0_s1 <= tofd_pkg::DIFF_W'(phase_sample_2) - tofd_pkg::DIFF_W'(phase_sample_0);
		d1_s1 <= tofd_pkg::DIFF_W'(phase_sample_3) - tofd_pkg::DIFF_W'(phase_sample_1);
	end

	// Phase path: pre-rotation plus 8 CORDIC stages, then wrap, scale
	// multiply, round/offset/clip. The valid bit rides along this path
	// and marks the result.
	tofd_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.d0       (d0_s1),
		.d1       (d1_s1),
		.phase    (phase)
	);

	tofd_depth u_depth (
		.clk    (clk),
		.arst_n (arst_n),
		.phase  (phase),
		.offset (depth_offset_q),
		.scale  (mm_per_radian_q),
		.res    (res)
	);

	// Amplitude path: squares, sum, 9 root stages, rounding, matched to
	// the phase path so both land in the same cycle.
	tofd_sqrt u_sqrt (
		.clk  (clk),
		.d0   (d0_s1),
		.d1   (d1_s1),
		.conf (confidence)
	);

	assign done            = res.valid;
	assign depth_q4        = res.depth;
	assign depth_saturated = res.sat;

endmodule

`default_nettype wire

FILE: bench/tb_tof_four_phase_depth.sv
`default_nettype none

module tb_tof_four_phase_depth;
	timeunit 1ns;
	timeprecision 1ps;

	import tofd_pkg::*;

	// run length and watchdog
	localparam int RANDOM_ITEMS = 1650;
	localparam int PHASES       = 8;
	localparam int WATCHDOG     = 200000;  // counted in clock cycles
	localparam int TAIL_CYCLES  = 20;      // pipeline is 13 deep, leave margin for strays

	// register slots past the end of the map, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	// CORDIC constants, Q.16 radians
	localparam longint ATAN_STEP [16] = '{
		51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2
	};
	localparam longint QUARTER_TURN = 102944;
	localparam longint FULL_TURN    = 411775;
	localparam longint WRAP_BELOW   = -65536;  // -1 rad
	localparam longint DEPTH_TOP    = 131071;
	localparam longint DEPTH_BOTTOM = -131072;

	typedef struct {
		logic signed [DEPTH_W-1:0] depth;
		logic        [CONF_W-1:0]  conf;
		logic                      sat;
	} depth_result_t;

	// Keeps a shadow of the two registers, works out depth/confidence for each
	// pixel taken by the block and matches the returned pixels in order.
	class depth_tracker;
		bit [OFFSET_W-1:0] offset;
		bit [SCALE_W-1:0]  scale;
		depth_result_t     due[$];
		int unsigned       fails;

		function new();
			offset = 16'd24000;
			scale  = 18'd81487;
			fails  = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_DEPTH_OFFSET: begin
					offset = data[OFFSET_W-1:0];
				end
				REG_MM_PER_RADIAN: begin
					scale = data[SCALE_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// vectoring CORDIC, 16 iterations, floor shifts
		static function longint phase_of(int d0, int d1);
			longint x, y, z, t, xs, ys;
			if (d0 == 0 && d1 == 0)
				return 0;
			x = longint'(d0) <<< 14;
			y = longint'(d1) <<< 14;
			z = 0;
			if (x < 0) begin
				if (y >= 0) begin
					t = x; x = y; y = -t; z = QUARTER_TURN;
				end else begin
					t = x; x = -y; y = t; z = -QUARTER_TURN;
				end
			end
			for (int i = 0; i < 16; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x += ys; y -= xs; z += ATAN_STEP[i];
				end else begin
					x -= ys; y += xs; z -= ATAN_STEP[i];
				end
			end
			return z;
		endfunction

		// integer sqrt, rounded to nearest
		static function longint magnitude_of(int d0, int d1);
			longint n, r, c;
			n = longint'(d0) * d0 + longint'(d1) * d1;
			r = 0;
			for (int k = 17; k >= 0; k--) begin
				c = r + (longint'(1) <<< k);
				if (c * c <= n)
					r = c;
			end
			if (n > r * r + r)
				r++;
			return r;
		endfunction

		function depth_result_t demod(logic signed [SAMPLE_W-1:0] s0, logic signed [SAMPLE_W-1:0] s1,
				logic signed [SAMPLE_W-1:0] s2, logic signed [SAMPLE_W-1:0] s3);
			depth_result_t res;
			int d0, d1;
			longint ph, q, dep;
			d0 = int'(s2) - int'(s0);
			d1 = int'(s3) - int'(s1);
			ph = phase_of(d0, d1);
			if (ph < WRAP_BELOW)
				ph += FULL_TURN;
			q = (longint'(scale) * ph + (longint'(1) <<< 19)) >>> 20;
			dep = longint'(offset) - q;
			res.sat = 1'b0;
			if (dep > DEPTH_TOP) begin
				dep = DEPTH_TOP; res.sat = 1'b1;
			end else if (dep < DEPTH_BOTTOM) begin
				dep = DEPTH_BOTTOM; res.sat = 1'b1;
			end
			res.depth = DEPTH_W'(dep);
			res.conf  = CONF_W'(magnitude_of(d0, d1));
			return res;
		endfunction

		function void note_pixel(logic signed [SAMPLE_W-1:0] s0, logic signed [SAMPLE_W-1:0] s1,
				logic signed [SAMPLE_W-1:0] s2, logic signed [SAMPLE_W-1:0] s3);
			due.push_back(demod(s0, s1, s2, s3));
		endfunction

		function void check_pixel(logic signed [DEPTH_W-1:0] depth, logic [CONF_W-1:0] conf,
				logic sat);
			depth_result_t exp_res;
			if (due.size() == 0) begin
				$error("result with no pixel in flight: depth_q4 %0d confidence %0d", depth, conf);
				fails++;
				return;
			end
			exp_res = due.pop_front();
			if (depth !== exp_res.depth) begin
				$error("depth_q4: expected %0d, got %0d", exp_res.depth, depth);
				fails++;
			end
			if (conf !== exp_res.conf) begin
				$error("confidence: expected %0d, got %0d", exp_res.conf, conf);
				fails++;
			end
			if (sat !== exp_res.sat) begin
				$error("depth_saturated: expected %0b, got %0b", exp_res.sat, sat);
				fails++;
			end
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass

	// DUT hookup; every input has a known value from time zero
	logic                         clk    = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start  = 1'b0;
	logic                         busy;
	logic signed [SAMPLE_W-1:0]   phase_sample_0 = '0;
	logic signed [SAMPLE_W-1:0]   phase_sample_1 = '0;
	logic signed [SAMPLE_W-1:0]   phase_sample_2 = '0;
	logic signed [SAMPLE_W-1:0]   phase_sample_3 = '0;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [CFG_IDX_W-1:0]         cfg_index = '0;
	logic [CFG_DATA_W-1:0]        cfg_data  = '0;
	logic                         done;
	logic signed [DEPTH_W-1:0]    depth_q4;
	logic        [CONF_W-1:0]     confidence;
	logic                         depth_saturated;

	depth_tracker board = new();

	// sender idling: either a random gap per pixel or a back-to-back burst
	int burst_left = 0;

	tof_four_phase_depth dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.phase_sample_0  (phase_sample_0),
		.phase_sample_1  (phase_sample_1),
		.phase_sample_2  (phase_sample_2),
		.phase_sample_3  (phase_sample_3),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.done            (done),
		.depth_q4        (depth_q4),
		.confidence      (confidence),
		.depth_saturated (depth_saturated)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Result side can't stall: every done cycle is a transfer. Sampled at the
	// edge, so we see the values from the cycle that edge ends.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			board.check_pixel(depth_q4, confidence, depth_saturated);
	end

	// Watchdog
	initial begin : watchdog
		int unsigned cycles;
		for (cycles = 0; cycles < WATCHDOG; cycles++)
			@(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	// Next gap for the sender. Mostly a random gap, sometimes a burst with none.
	function automatic int next_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0)
			burst_left = $urandom_range(20, 60);
		return $urandom_range(0, 6);
	endfunction

	// One pixel transfer. Called right after a rising edge. start is only
	// dropped when there's a gap, so back-to-back pixels keep it high with no
	// low/high pair in the same step. busy is looked at on the falling edge:
	// it can only move at a rising edge, so that value holds for the next one.
	task automatic send_pixel(int gap, logic signed [SAMPLE_W-1:0] s0,
			logic signed [SAMPLE_W-1:0] s1, logic signed [SAMPLE_W-1:0] s2,
			logic signed [SAMPLE_W-1:0] s3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start          <= 1'b1;
		phase_sample_0 <= s0;
		phase_sample_1 <= s1;
		phase_sample_2 <= s2;
		phase_sample_3 <= s3;
		do @(negedge clk); while (busy !== 1'b0);
		@(posedge clk);
		board.note_pixel(s0, s1, s2, s3);
	endtask

	// Stop sending and wait until every pixel in flight has come back.
	// Always waits for a rising edge so the next start never shares a step
	// with this drop.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	// Register write on its own channel; only called with the pipeline empty.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(negedge clk); while (cfg_ready !== 1'b1);
		@(posedge clk);
		board.set_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// s2 - s0 = d0, s3 - s1 = d1 with the 0/90 deg samples at zero
	task automatic send_diff(int d0, int d1);
		send_pixel($urandom_range(0, 6), '0, '0, SAMPLE_W'(d0), SAMPLE_W'(d1));
	endtask

	function automatic logic signed [SAMPLE_W-1:0] corner_value();
		case ($urandom_range(0, 3))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'sd0;
			default: return -16'sd1;
		endcase
	endfunction

	task automatic run_directed();
		// zero differences: all zero, equal pairs, all min, all max
		send_pixel(0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_pixel(2, 16'sd1234, -16'sd777, 16'sd1234, -16'sd777);
		send_pixel(0, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
		send_pixel(1, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
		// full-scale differences on the axes
		send_pixel(3, -16'sd32768, 16'sd0, 16'sd32767, 16'sd0);
		send_pixel(0, 16'sd32767, 16'sd0, -16'sd32768, 16'sd0);
		send_pixel(0, 16'sd0, -16'sd32768, 16'sd0, 16'sd32767);
		send_pixel(4, 16'sd0, 16'sd32767, 16'sd0, -16'sd32768);
		// full-scale in each quadrant, max confidence
		send_pixel(0, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
		send_pixel(6, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
		send_pixel(0, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
		send_pixel(5, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
		// small vectors, quarter-turn prerotation and wrap around -pi
		send_diff(-1, -1);
		send_diff(-1, 0);
		send_diff(1, -1);
		send_diff(3, 4);
		send_diff(-100, -1);
		send_diff(-100, 1);
		// right around the -1 rad wrap point
		send_diff(540, -841);
		send_diff(5403, -8415);
		send_diff(5403, -8414);
		send_diff(5403, -8416);
	endtask

	// Register setting for each phase: defaults, both extremes, mixes,
	// out-of-width data and writes past the register map.
	task automatic apply_setting(int phase);
		case (phase)
			0: begin
				write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
				write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
			end
			1: begin
				write_reg(REG_DEPTH_OFFSET, '0);
				write_reg(REG_MM_PER_RADIAN, '0);
			end
			2: begin
				write_reg(REG_DEPTH_OFFSET, 18'h0FFFF);
				write_reg(REG_MM_PER_RADIAN, 18'h3FFFF);
			end
			3: begin
				write_reg(REG_DEPTH_OFFSET, '0);
			end
			4: begin
				// top two data bits land outside the 16 bit offset
				write_reg(REG_DEPTH_OFFSET, 18'h3FFFF);
				write_reg(REG_MM_PER_RADIAN, '0);
			end
			default: begin
				write_reg(REG_DEPTH_OFFSET, CFG_DATA_W'($urandom));
				write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
				write_reg(REG_MM_PER_RADIAN, CFG_DATA_W'($urandom));
				write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
			end
		endcase
	endtask

	task automatic run_random(int count);
		logic signed [SAMPLE_W-1:0] a, b, c, d;
		int kind;
		for (int n = 0; n < count; n++) begin
			// hold off once per phase until the pipeline is empty
			if (n == count / 2)
				drain();
			a = SAMPLE_W'($urandom);
			b = SAMPLE_W'($urandom);
			c = SAMPLE_W'($urandom);
			d = SAMPLE_W'($urandom);
			kind = $urandom_range(0, 9);
			case (kind)
				6, 7: begin
					// short difference vectors: fine angles, low confidence
					c = a + SAMPLE_W'($urandom_range(0, 127)) - 16'sd64;
					d = b + SAMPLE_W'($urandom_range(0, 127)) - 16'sd64;
				end
				8: begin
					a = corner_value();
					b = corner_value();
					c = corner_value();
					d = corner_value();
				end
				9: begin
					case ($urandom_range(0, 2))
						0: c = a;
						1: d = b;
						default: begin
							c = a;
							d = b;
						end
					endcase
				end
				default: begin
				end
			endcase
			send_pixel(next_gap(), a, b, c, d);
		end
	endtask

	initial begin
		// reset once
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults straight out of reset
		run_directed();

		for (int p = 0; p < PHASES; p++) begin
			drain();
			apply_setting(p);
			run_random(RANDOM_ITEMS / PHASES);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (board.fails == 0 && board.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
